// ===== rtl/core/trg_pkg.sv =====
// Shared constants, types and helpers for the trapezoidal ramp generator.
`default_nettype none
package trg_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int VALUE_BITS     = 32;
   localparam int STEP_BITS      = 31;
   localparam int FRAC_BITS      = 17;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [FRAC_BITS-1:0] ONE_Q16 = 17'h10000;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_STEP_MAX   = 2'd0;
   localparam reg_index_type REG_ACCEL_FRAC = 2'd1;
   localparam reg_index_type REG_DECEL_FRAC = 2'd2;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_IDLE   = 2'd0;
   localparam phase_type PH_ACCEL  = 2'd1;
   localparam phase_type PH_CRUISE = 2'd2;
   localparam phase_type PH_DECEL  = 2'd3;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      logic signed [32:0] d;
      logic signed [32:0] n;
      d = 33'(a) - 33'(b);
      n = -d;
      return d[32] ? n[31:0] : d[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trapezoidal_ramp_generator_core.sv =====
// Trapezoidal ramp generator: stream in/out, APB registers, shared multiplier and divider.
//
//  channel | ports                         | payload
//  req     | req_tvalid/tready/tdata       | target (signed Q16.16)
//  rsp     | rsp_tvalid/tready/tdata/tuser | value; busy_res, phase
//  csr     | csr_psel..csr_pready          | step_max, accel_fraction, decel_fraction
//
// After a target change or a register write a tick also runs two 32-step restoring
// divisions through the one divider, each skipped if its divisor is zero or its
// quotient saturates. Early arrival or idle skips the step and move states.
// Synchronous active-high reset; no item is taken until the previous one is done.
// The result register holds a finished transaction while the next one is worked on.
`default_nettype none
module trapezoidal_ramp_generator_core #(
   parameter int COUNT_BITS = trg_pkg::COUNT_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [31:0]                        req_tdata,   // [31:0] target
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [31:0]                        rsp_tdata,   // [31:0] value
   output logic [2:0]                         rsp_tuser,   // [0] busy_res, [2:1] phase
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [trg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [trg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [trg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQ    = 4'd1;
   localparam logic [3:0] S_DA    = 4'd2;
   localparam logic [3:0] S_DINIT = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_DC    = 4'd5;
   localparam logic [3:0] S_PA    = 4'd6;
   localparam logic [3:0] S_PC    = 4'd7;
   localparam logic [3:0] S_STG   = 4'd8;
   localparam logic [3:0] S_CHK   = 4'd9;
   localparam logic [3:0] S_STEP  = 4'd10;
   localparam logic [3:0] S_MOVE  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   // configuration
   logic [trg_pkg::STEP_BITS-1:0] step_max_ff;
   logic [trg_pkg::FRAC_BITS-1:0] accel_frac_ff;
   logic [trg_pkg::FRAC_BITS-1:0] decel_frac_ff;

   // ramp state
   logic [3:0]                state_ff;
   logic signed [31:0]        current_value_ff;
   logic signed [31:0]        start_value_ff;
   logic signed [31:0]        previous_target_ff;
   logic signed [31:0]        target_ff;
   logic [31:0]               total_span_ff;
   logic [31:0]               step_now_ff;
   logic [31:0]               accel_inc_ff;
   logic [31:0]               decel_inc_ff;
   logic [COUNT_BITS-1:0]     ramp_count_ff;
   logic [COUNT_BITS-1:0]     down_count_ff;
   logic                      moving_ff;
   logic                      dirty_ff;

   // shared arithmetic
   logic [63:0]               prod_ff;
   logic [61:0]               sq_ff;
   logic [47:0]               den_ff;
   logic [47:0]               rem_ff;
   logic [31:0]               num_ff;
   logic [31:0]               quo_ff;
   logic [4:0]                div_cnt_ff;
   logic                      div_sel_ff;

   // per-tick working values
   logic [31:0]               trav_ff;
   logic [31:0]               dist_ff;
   logic                      acc_ff;
   trg_pkg::phase_type        stage_ff;
   logic [31:0]               add_ff;
   logic                      res_busy_ff;
   trg_pkg::phase_type        res_phase_ff;

   logic                      csr_wr;
   trg_pkg::reg_index_type    csr_idx;
   logic                      req_take;
   logic signed [31:0]        req_target;
   logic                      restart;
   logic [trg_pkg::FRAC_BITS-1:0] fa_cl;
   logic [trg_pkg::FRAC_BITS-1:0] fc_cl;
   logic [trg_pkg::FRAC_BITS:0]   frac_sum;
   logic [trg_pkg::FRAC_BITS-1:0] fa_eff;
   logic [trg_pkg::FRAC_BITS-1:0] fc_eff;
   logic [31:0]               mul_a;
   logic [31:0]               mul_b;
   logic                      mul_en;
   logic [48:0]               div_trial;
   logic                      div_ge;
   logic [31:0]               div_quo_next;
   logic [47:0]               trav_q16;
   logic                      done_now;
   logic [31:0]               step_max_w;
   logic [31:0]               add_up;
   logic [31:0]               add_dn0;
   logic [31:0]               add_dn1;
   logic [31:0]               add_dn2;
   logic [31:0]               add_sel;
   logic signed [32:0]        move_sum;
   logic signed [31:0]        move_sat;
   logic                      rsp_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      case (csr_idx)
         trg_pkg::REG_STEP_MAX:   csr_prdata = 32'(step_max_ff);
         trg_pkg::REG_ACCEL_FRAC: csr_prdata = 32'(accel_frac_ff);
         trg_pkg::REG_DECEL_FRAC: csr_prdata = 32'(decel_frac_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_target = signed'(req_tdata);
   assign restart    = (req_target != previous_target_ff);
   assign rsp_free   = !rsp_tvalid || rsp_tready;

   assign fa_cl    = (accel_frac_ff > trg_pkg::ONE_Q16) ? trg_pkg::ONE_Q16 : accel_frac_ff;
   assign fc_cl    = (decel_frac_ff > trg_pkg::ONE_Q16) ? trg_pkg::ONE_Q16 : decel_frac_ff;
   assign frac_sum = 18'(fa_cl) + 18'(fc_cl);
   assign fa_eff   = (frac_sum > 18'(trg_pkg::ONE_Q16)) ? '0 : fa_cl;
   assign fc_eff   = (frac_sum > 18'(trg_pkg::ONE_Q16)) ? '0 : fc_cl;

   assign step_max_w = 32'(step_max_ff);

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = step_max_w;
            mul_b = step_max_w;
         end
         S_DA, S_PA: begin
            mul_a = total_span_ff;
            mul_b = 32'(fa_eff);
         end
         S_DC: begin
            mul_a = total_span_ff;
            mul_b = 32'(fc_eff);
         end
         S_PC: begin
            mul_a = total_span_ff;
            mul_b = 32'(trg_pkg::ONE_Q16 - fc_eff);
         end
         S_CHK: begin
            if (stage_ff == trg_pkg::PH_DECEL) begin
               mul_a = decel_inc_ff;
               mul_b = 32'(down_count_ff);
            end else begin
               mul_a = accel_inc_ff;
               mul_b = 32'(ramp_count_ff);
            end
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign div_trial    = {rem_ff, num_ff[31]};
   assign div_ge       = (div_trial >= {1'b0, den_ff});
   assign div_quo_next = {quo_ff[30:0], div_ge};

   assign trav_q16 = {trav_ff[31:0], 16'd0};

   assign done_now = (dist_ff == '0) ||
                     ((dist_ff <= step_max_w) &&
                      ((fc_eff == '0) || (decel_inc_ff == '0) ||
                       ((stage_ff == trg_pkg::PH_DECEL) && (step_now_ff <= decel_inc_ff))));

   always_comb begin
      add_up  = (prod_ff > 64'(step_max_w)) ? step_max_w : prod_ff[31:0];
      add_dn0 = (prod_ff >= 64'(step_max_w)) ? 32'd0 : (step_max_w - prod_ff[31:0]);
      add_dn1 = (add_dn0 < decel_inc_ff) ? decel_inc_ff : add_dn0;
      add_dn2 = (add_dn1 > step_max_w) ? step_max_w : add_dn1;
      case (stage_ff)
         trg_pkg::PH_ACCEL: add_sel = add_up;
         trg_pkg::PH_DECEL: add_sel = add_dn2;
         default:           add_sel = step_max_w;
      endcase
   end

   always_comb begin
      if (target_ff > current_value_ff) begin
         move_sum = 33'(current_value_ff) + signed'({1'b0, add_ff});
      end else begin
         move_sum = 33'(current_value_ff) - signed'({1'b0, add_ff});
      end
      if (move_sum > 33'sd2147483647) begin
         move_sat = 32'sh7FFFFFFF;
      end else if (move_sum < -33'sd2147483648) begin
         move_sat = 32'sh80000000;
      end else begin
         move_sat = move_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_max_ff   <= '0;
         accel_frac_ff <= '0;
         decel_frac_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            trg_pkg::REG_STEP_MAX:   step_max_ff   <= csr_pwdata[trg_pkg::STEP_BITS-1:0];
            trg_pkg::REG_ACCEL_FRAC: accel_frac_ff <= csr_pwdata[trg_pkg::FRAC_BITS-1:0];
            trg_pkg::REG_DECEL_FRAC: decel_frac_ff <= csr_pwdata[trg_pkg::FRAC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         current_value_ff   <= '0;
         start_value_ff     <= '0;
         previous_target_ff <= '0;
         total_span_ff      <= '0;
         step_now_ff        <= '0;
         accel_inc_ff       <= '0;
         decel_inc_ff       <= '0;
         ramp_count_ff      <= '0;
         down_count_ff      <= '0;
         moving_ff          <= 1'b1;
         dirty_ff           <= 1'b0;
         rsp_tvalid         <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && state_ff != S_OUT) begin
            rsp_tvalid <= 1'b0;
         end
         if (csr_wr) begin
            dirty_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  target_ff          <= req_target;
                  previous_target_ff <= req_target;
                  if (restart) begin
                     total_span_ff  <= trg_pkg::abs_diff(req_target, current_value_ff);
                     start_value_ff <= current_value_ff;
                     ramp_count_ff  <= '0;
                     down_count_ff  <= '0;
                     moving_ff      <= 1'b1;
                  end
                  state_ff <= (restart || dirty_ff) ? S_SQ : S_PA;
               end
            end
            S_SQ: state_ff <= S_DA;
            S_DA: begin
               sq_ff      <= prod_ff[61:0];
               div_sel_ff <= 1'b0;
               state_ff   <= S_DINIT;
            end
            S_DC: begin
               div_sel_ff <= 1'b1;
               state_ff   <= S_DINIT;
            end
            S_DINIT: begin
               den_ff     <= prod_ff[47:0];
               rem_ff     <= 48'(sq_ff[61:17]);
               num_ff     <= {sq_ff[16:0], 15'd0};
               quo_ff     <= '0;
               div_cnt_ff <= '0;
               if (prod_ff[47:0] == '0 || 48'(sq_ff[61:17]) >= prod_ff[47:0]) begin
                  if (div_sel_ff) begin
                     decel_inc_ff <= (prod_ff[47:0] == '0) ? 32'd0 : 32'hFFFFFFFF;
                     dirty_ff     <= 1'b0;
                     state_ff     <= S_PA;
                  end else begin
                     accel_inc_ff <= (prod_ff[47:0] == '0) ? 32'd0 : 32'hFFFFFFFF;
                     state_ff     <= S_DC;
                  end
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff     <= div_ge ? 48'(div_trial - {1'b0, den_ff}) : div_trial[47:0];
               num_ff     <= {num_ff[30:0], 1'b0};
               quo_ff     <= div_quo_next;
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'd31) begin
                  if (div_sel_ff) begin
                     decel_inc_ff <= div_quo_next;
                     dirty_ff     <= 1'b0;
                     state_ff     <= S_PA;
                  end else begin
                     accel_inc_ff <= div_quo_next;
                     state_ff     <= S_DC;
                  end
               end
            end
            S_PA: begin
               trav_ff <= trg_pkg::abs_diff(current_value_ff, start_value_ff);
               dist_ff <= trg_pkg::abs_diff(current_value_ff, target_ff);
               if (!moving_ff || total_span_ff == '0) begin
                  moving_ff    <= 1'b0;
                  res_busy_ff  <= 1'b0;
                  res_phase_ff <= trg_pkg::PH_IDLE;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_PC;
               end
            end
            S_PC: begin
               acc_ff   <= (fa_eff != '0) && (trav_q16 <= prod_ff[47:0]);
               state_ff <= S_STG;
            end
            S_STG: begin
               if (acc_ff) begin
                  stage_ff <= trg_pkg::PH_ACCEL;
               end else if ((fc_eff != '0) && (trav_q16 > prod_ff[47:0])) begin
                  stage_ff <= trg_pkg::PH_DECEL;
               end else begin
                  stage_ff <= trg_pkg::PH_CRUISE;
               end
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (done_now) begin
                  current_value_ff <= target_ff;
                  start_value_ff   <= target_ff;
                  moving_ff        <= 1'b0;
                  res_busy_ff      <= 1'b0;
                  res_phase_ff     <= trg_pkg::PH_IDLE;
                  state_ff         <= S_OUT;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               add_ff      <= add_sel;
               step_now_ff <= add_sel;
               if (ramp_count_ff != '1) begin
                  ramp_count_ff <= ramp_count_ff + COUNT_BITS'(1);
               end
               if (stage_ff == trg_pkg::PH_DECEL && down_count_ff != '1) begin
                  down_count_ff <= down_count_ff + COUNT_BITS'(1);
               end
               state_ff <= S_MOVE;
            end
            S_MOVE: begin
               current_value_ff <= move_sat;
               res_busy_ff      <= 1'b1;
               res_phase_ff     <= stage_ff;
               state_ff         <= S_OUT;
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_tvalid <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && rsp_free) begin
         rsp_tdata <= current_value_ff;
         rsp_tuser <= {res_phase_ff, res_busy_ff};
      end
   end

   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] != trg_pkg::PH_IDLE)))
      else $error("busy flag and phase disagree");

   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> (add_ff <= step_max_w))
      else $error("step exceeds step_max");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("second transaction taken while one is in progress");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == 5'd31) |=> (state_ff == S_DC || state_ff == S_PA))
      else $error("divider did not hand over after its last step");

endmodule
`default_nettype wire

// ===== verif/trapezoidal_ramp_generator_core_tb.sv =====
// Self-checking testbench for the trapezoidal ramp generator core: directed and random ticks.
module trapezoidal_ramp_generator_core_tb;
   import trg_pkg::*;

   localparam int IDLE_PCT     = 28;
   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic signed [31:0] value;
      logic               busy;
      phase_type          phase;
   } ramp_output_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [31:0]              req_tdata   = '0;    // [31:0] target
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [31:0]              rsp_tdata;           // [31:0] value
   logic [2:0]               rsp_tuser;           // [0] busy_res, [2:1] phase
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor state and register copies
   logic [STEP_BITS-1:0]      cfg_step_max = '0;
   logic [FRAC_BITS-1:0]      cfg_accel    = '0;
   logic [FRAC_BITS-1:0]      cfg_decel    = '0;
   logic signed [31:0]        pos_now      = '0;
   logic signed [31:0]        pos_origin   = '0;
   logic signed [31:0]        goal_prev    = '0;
   logic [31:0]               span_now     = '0;
   logic [31:0]               step_last    = '0;
   logic [31:0]               inc_up       = '0;
   logic [31:0]               inc_down     = '0;
   logic [COUNT_BITS_DEF-1:0] ramp_ticks   = '0;
   logic [COUNT_BITS_DEF-1:0] brake_ticks  = '0;
   logic                      in_motion    = 1'b1;

   ramp_output_type predicted_ticks[$];
   int           mismatch_count = 0;
   int           items_sent     = 0;
   int           quiet_cycles   = 0;
   int           idle_pct       = IDLE_PCT;

   trapezoidal_ramp_generator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] span_between(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return (d < 0) ? 32'(-d) : 32'(d);
   endfunction

   // Q16.16 ramp increment: step^2 * 2^15 / weight, saturated, zero weight gives zero
   function automatic logic [31:0] ramp_increment(input logic [63:0] step_sq,
                                                  input logic [63:0] weight);
      logic [127:0] quotient;
      if (weight == 0) return '0;
      quotient = (128'(step_sq) << 15) / 128'(weight);
      return (quotient > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
   endfunction

   function automatic logic [COUNT_BITS_DEF-1:0] tick_up(input logic [COUNT_BITS_DEF-1:0] c);
      return (&c) ? c : c + COUNT_BITS_DEF'(1);
   endfunction

   function automatic ramp_output_type advance_ramp(input logic signed [31:0] goal);
      logic [FRAC_BITS-1:0] share_up;
      logic [FRAC_BITS-1:0] share_down;
      logic [63:0]          step_sq;
      logic [63:0]          moved;
      logic [63:0]          prod;
      logic [31:0]          remaining;
      logic [31:0]          add;
      logic [31:0]          step_cap;
      phase_type            stage;
      logic                 arrived;
      logic signed [33:0]   next_pos;
      ramp_output_type      tick;
      share_up   = (cfg_accel > ONE_Q16) ? ONE_Q16 : cfg_accel;
      share_down = (cfg_decel > ONE_Q16) ? ONE_Q16 : cfg_decel;
      step_cap   = {1'b0, cfg_step_max};
      if (goal != goal_prev) begin
         span_now    = span_between(goal, pos_now);
         pos_origin  = pos_now;
         ramp_ticks  = '0;
         brake_ticks = '0;
         in_motion   = 1'b1;
      end
      goal_prev = goal;
      if (18'(share_up) + 18'(share_down) > 18'(ONE_Q16)) begin
         share_up   = '0;
         share_down = '0;
      end
      step_sq  = 64'(step_cap) * 64'(step_cap);
      inc_up   = ramp_increment(step_sq, 64'(span_now) * 64'(share_up));
      inc_down = ramp_increment(step_sq, 64'(span_now) * 64'(share_down));
      tick.value = pos_now;
      tick.busy  = 1'b0;
      tick.phase = PH_IDLE;
      if (!in_motion || span_now == 0) begin
         in_motion = 1'b0;
         return tick;
      end
      remaining = span_between(pos_now, goal);
      moved     = 64'(span_between(pos_now, pos_origin)) << 16;
      if (share_up != 0 && moved <= 64'(span_now) * 64'(share_up))
         stage = PH_ACCEL;
      else if (share_down != 0 && moved > 64'(span_now) * 64'(ONE_Q16 - share_down))
         stage = PH_DECEL;
      else
         stage = PH_CRUISE;
      arrived = (remaining == 0) ||
                (remaining <= step_cap &&
                 (share_down == 0 || inc_down == 0 ||
                  (stage == PH_DECEL && step_last <= inc_down)));
      if (arrived) begin
         pos_now    = goal;
         pos_origin = goal;
         in_motion  = 1'b0;
         tick.value = goal;
         return tick;
      end
      case (stage)
         PH_ACCEL: begin
            prod = 64'(inc_up) * 64'(ramp_ticks);
            add  = (prod > 64'(step_cap)) ? step_cap : prod[31:0];
         end
         PH_DECEL: begin
            prod = 64'(inc_down) * 64'(brake_ticks);
            add  = (prod >= 64'(step_cap)) ? 32'd0 : step_cap - prod[31:0];
            if (add < inc_down) add = inc_down;
            if (add > step_cap) add = step_cap;
            brake_ticks = tick_up(brake_ticks);
         end
         default: add = step_cap;
      endcase
      ramp_ticks = tick_up(ramp_ticks);
      step_last  = add;
      if (goal > pos_now)
         next_pos = $signed({{2{pos_now[31]}}, pos_now}) + $signed({2'b00, add});
      else
         next_pos = $signed({{2{pos_now[31]}}, pos_now}) - $signed({2'b00, add});
      if (next_pos > 34'sd2147483647)
         next_pos = 34'sd2147483647;
      else if (next_pos < -34'sd2147483648)
         next_pos = -34'sd2147483648;
      pos_now    = next_pos[31:0];
      tick.value = pos_now;
      tick.busy  = 1'b1;
      tick.phase = stage;
      return tick;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %0d: %s got %0h expected %0h", mismatch_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin : check_outputs
      ramp_output_type seen;
      ramp_output_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.value = $signed(rsp_tdata);
         seen.busy  = rsp_tuser[0];
         seen.phase = rsp_tuser[2:1];
         if (predicted_ticks.size() == 0) begin
            report_mismatch("unexpected transaction, value", rsp_tdata, 32'd0);
         end else begin
            want = predicted_ticks.pop_front();
            if (seen.value !== want.value) report_mismatch("value", seen.value, want.value);
            if (seen.busy !== want.busy) report_mismatch("busy_res", seen.busy, want.busy);
            if (seen.phase !== want.phase) report_mismatch("phase", seen.phase, want.phase);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_target(input logic signed [31:0] goal);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= goal;
      do @(posedge clock); while (!req_tready);
      predicted_ticks.push_back(advance_ramp(goal));
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_ticks.size() != 0);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_STEP_MAX:   cfg_step_max = data[STEP_BITS-1:0];
         REG_ACCEL_FRAC: cfg_accel    = data[FRAC_BITS-1:0];
         REG_DECEL_FRAC: cfg_decel    = data[FRAC_BITS-1:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [STEP_BITS-1:0] step,
                                    input logic [FRAC_BITS-1:0] accel,
                                    input logic [FRAC_BITS-1:0] decel);
      wait_drained();
      repeat (4) @(posedge clock);
      write_csr(REG_STEP_MAX, 32'(step));
      write_csr(REG_ACCEL_FRAC, 32'(accel));
      write_csr(REG_DECEL_FRAC, 32'(decel));
   endtask

   // hold one target until the profile has finished plus up to two idle ticks, or max_ticks
   task automatic run_profile(input logic signed [31:0] goal, input int max_ticks);
      int ticks;
      int tail;
      tail  = $urandom_range(1, 3);
      ticks = 0;
      while (ticks < max_ticks && tail > 0) begin
         send_target(goal);
         if (!in_motion) tail--;
         ticks++;
      end
   endtask

   function automatic logic signed [31:0] near_goal();
      longint reach;
      longint aim;
      if (cfg_step_max == 0)
         reach = longint'($urandom_range(1, 32'h4_0000));
      else
         reach = longint'(cfg_step_max) * $urandom_range(2, 40) + $urandom_range(0, 255);
      aim = $urandom_range(0, 1) ? longint'(pos_now) + reach : longint'(pos_now) - reach;
      if (aim > 64'sd2147483647) aim = 64'sd2147483647;
      if (aim < -64'sd2147483648) aim = -64'sd2147483648;
      return aim[31:0];
   endfunction

   task automatic test_zero_step();
      send_target(32'sd0);
      send_target(32'sh0001_0000);
      send_target(32'sh0001_0000);
      send_target(32'sd0);
   endtask

   task automatic test_saturation();
      program_registers(31'h7FFF_FFFF, '0, '0);
      send_target(32'sh7FFF_FFFF);
      repeat (3) send_target(32'sh8000_0000);
      repeat (2) send_target(32'sd10);
      program_registers(31'h7FFF_FFFF, '0, 17'd1);
      repeat (2) send_target(32'sh7FFF_FFFF);
      repeat (3) send_target(-32'sd10);
      repeat (2) send_target(32'sh8000_0000);
   endtask

   task automatic test_fraction_limits();
      program_registers(31'h1_0000, 17'h1_FFFF, '0);
      repeat (5) send_target(32'sh0004_0000);
      program_registers(31'h1_0000, 17'h9000, 17'h9000);
      repeat (3) send_target(32'sd0);
   endtask

   task automatic test_random_profiles();
      int                   start_count;
      int                   phase_no;
      int                   seq;
      logic [STEP_BITS-1:0] step;
      logic [FRAC_BITS-1:0] fa;
      logic [FRAC_BITS-1:0] fc;
      start_count = items_sent;
      phase_no    = 0;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:          step = '0;
            1:          step = 31'h7FFF_FFFF;
            2, 3:       step = STEP_BITS'($urandom_range(1, 32'hFFFF));
            4, 5, 6, 7: step = STEP_BITS'($urandom());
            default:    step = STEP_BITS'($urandom_range(32'h1000, 32'h100_0000));
         endcase
         case ($urandom_range(0, 9))
            0: begin
               fa = FRAC_BITS'($urandom());
               fc = FRAC_BITS'($urandom());
            end
            1: begin
               fa = ONE_Q16;
               fc = '0;
            end
            2: begin
               fa = '0;
               fc = ONE_Q16;
            end
            3: begin
               fa = '0;
               fc = '0;
            end
            4: begin
               fa = 17'h1_FFFF;
               fc = FRAC_BITS'($urandom_range(0, 32'h1_FFFF));
            end
            default: begin
               fa = FRAC_BITS'($urandom_range(0, 65536));
               fc = FRAC_BITS'($urandom_range(0, 65536 - fa));
            end
         endcase
         program_registers(step, fa, fc);
         idle_pct = (phase_no == 2) ? 0 : IDLE_PCT;
         for (seq = 0; seq < 4 && items_sent - start_count < RANDOM_ITEMS; seq++) begin
            case ($urandom_range(0, 9))
               0:       repeat ($urandom_range(1, 6)) send_target($urandom());
               1:       run_profile(near_goal(), $urandom_range(2, 12));
               default: run_profile(near_goal(), (cfg_step_max == 0) ? 4 : 200);
            endcase
            if ($urandom_range(0, 7) == 0) wait_drained();
         end
         phase_no++;
      end
      idle_pct = IDLE_PCT;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_step();
      test_saturation();
      test_fraction_limits();
      test_random_profiles();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
